[src/palette_frame_delta_encoder_top_macros.svh]
// Assertion macros used by the palette frame delta encoder top level.
`ifndef PALETTE_FRAME_DELTA_ENCODER_TOP_MACROS_SVH
`define PALETTE_FRAME_DELTA_ENCODER_TOP_MACROS_SVH

`ifndef SYNTH
// Clocked property, disabled while reset is asserted.
`define PFDE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pfde assertion failed");
// Condition that must never be true outside reset.
`define PFDE_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("pfde forbidden condition seen");
`else
`define PFDE_ASSERT(label, clk, rstn, prop)
`define PFDE_NEVER(label, clk, rstn, cond)
`endif

`endif

[src/pfde_pkg.sv]
// Package of the palette frame delta encoder: codes, state type and scan structs.
`default_nettype none

package pfde_pkg;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DIFF = 1'b1;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_DIRTY = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SKIP = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_DIRTY_CAP   = 1'b1;

    localparam logic [8:0]  FRAME_WIDTH_RST = 9'd16;
    localparam logic [16:0] DIRTY_CAP_RST   = 17'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_FINISH
    } pfde_state_t;

    typedef struct packed {
        logic        start;
        logic [23:0] key;
    } scan_req_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [7:0] index;
    } scan_rsp_t;

endpackage

`default_nettype wire

[src/pfde_palette_ram.sv]
// Palette colour RAM: one write port, one read port with registered read data.
`default_nettype none

module pfde_palette_ram
    import pfde_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [23:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [23:0]   rd_data
);

    logic [23:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/pfde_scan.sv]
// Palette scanner: walks the filled RAM entries one per cycle looking for a colour.
`default_nettype none

module pfde_scan
    import pfde_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scan_req_t        req,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [23:0]      rd_data,
    output logic                  rd_en,
    output logic      [IDX_W-1:0] rd_addr,
    output scan_rsp_t             rsp
);

    logic             busy_reg,      busy_next;
    logic [CNT_W-1:0] issue_reg,     issue_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg,   cmp_idx_next;
    logic [23:0]      key_reg,       key_next;
    logic             done_reg,      done_next;
    logic             found_reg,     found_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;

    logic more;
    logic hit;
    logic finish;

    assign more    = issue_reg < count;
    assign hit     = cmp_valid_reg && (rd_data == key_reg);
    assign finish  = busy_reg && (hit || (!more && !cmp_valid_reg));
    assign rd_en   = busy_reg && more && !hit;
    assign rd_addr = issue_reg[IDX_W-1:0];

    always_comb
    begin
        busy_next      = busy_reg;
        issue_next     = issue_reg;
        cmp_valid_next = rd_en;
        cmp_idx_next   = rd_en ? issue_reg[IDX_W-1:0] : cmp_idx_reg;
        key_next       = key_reg;
        done_next      = finish;
        found_next     = finish ? hit : found_reg;
        idx_next       = finish ? cmp_idx_reg : idx_reg;
        if (rd_en)
        begin
            issue_next = issue_reg + CNT_W'(1);
        end
        if (finish)
        begin
            busy_next = 1'b0;
        end
        if (req.start)
        begin
            busy_next      = 1'b1;
            issue_next     = '0;
            cmp_valid_next = 1'b0;
            key_next       = req.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            issue_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            issue_reg     <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        idx_reg     <= idx_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.index = 8'(idx_reg);

endmodule

`default_nettype wire

[src/pfde_position.sv]
// Raster position tracker: column wraps at the frame width, row saturates.
`default_nettype none

module pfde_position
    import pfde_pkg::*;
#(
    parameter int MAX_DIM = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       clear,
    input  wire logic       advance,
    input  wire logic [8:0] frame_width,
    output logic      [7:0] column,
    output logic      [7:0] row
);

    localparam int DIM_LIM = (MAX_DIM > 256) ? 256 : MAX_DIM;

    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [8:0] width_eff;

    always_comb
    begin
        priority if (frame_width == 9'd0)
        begin
            width_eff = 9'd1;
        end
        else if (frame_width > 9'(DIM_LIM))
        begin
            width_eff = 9'(DIM_LIM);
        end
        else
        begin
            width_eff = frame_width;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (({1'b0, col_reg} + 9'd1) >= width_eff)
            begin
                col_next = '0;
                // hold the row at its last value once the bottom is reached
                if (({1'b0, row_reg} + 9'd1) < 9'(DIM_LIM))
                begin
                    row_next = row_reg + 8'd1;
                end
            end
            else
            begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign column = col_reg;
    assign row    = row_reg;

endmodule

`default_nettype wire

[src/palette_frame_delta_encoder_top.sv]
// Top level of the palette frame delta encoder: control sequencer, counters, output register.
`default_nettype none

// Palette builder and frame differ for raster-order RGBA pixels. Command 0 adds the
// pixel's RGB colour to the palette RAM (no duplicates) and answers with its index;
// command 1 emits a dirty record when the pixel changed, up to dirty_capacity records
// per frame. One word is processed at a time; a word that needs a palette lookup
// walks the filled palette RAM one entry per cycle through its single read port, while a
// word that needs no lookup skips the walk. A word with a result waits in its finish
// state while the output register still holds an unaccepted word. The result sits in an
// output register, so the next word is taken while the previous result waits. The
// palette RAM needs no clearing after reset.

`include "palette_frame_delta_encoder_top_macros.svh"

module palette_frame_delta_encoder_top
    import pfde_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_DIM       = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic        start_req,
    input  wire logic [31:0] pixel,
    input  wire logic [31:0] prev_pixel,
    input  wire logic        has_prev,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic      [7:0]  pixel_x,
    output logic      [7:0]  pixel_y,
    output logic      [7:0]  palette_index,
    output logic      [1:0]  status
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    pfde_state_t state_reg, state_next;

    logic [8:0]       frame_width_reg;
    logic [16:0]      dirty_cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic             failed_reg;
    logic [16:0]      emitted_reg;

    logic             cmd_reg;
    logic [31:0]      pixel_reg;
    logic [31:0]      prev_reg;
    logic             has_prev_reg;

    logic             has_res_reg;
    logic [1:0]       res_status_reg;
    logic [7:0]       res_idx_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_x_reg;
    logic [7:0]       out_y_reg;
    logic [7:0]       out_idx_reg;
    logic [1:0]       out_status_reg;

    logic             accept;
    logic             alpha_zero;
    logic             differs;
    logic             need_scan;
    logic             slot_free;
    logic             fin_fire;
    logic             scan_hit_done;
    logic             room;
    logic             pal_wr_en;

    scan_req_t        scan_req;
    scan_rsp_t        scan_rsp;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [23:0]      rd_data;
    logic [7:0]       column;
    logic [7:0]       row;

    assign accept     = in_valid && in_ready;
    assign alpha_zero = (pixel_reg[7:0] == 8'd0);
    assign differs    = has_prev_reg ? (pixel_reg != prev_reg) : !alpha_zero;
    assign slot_free  = !out_valid_reg || out_ready;
    assign room       = count_reg < CNT_W'(PALETTE_DEPTH);

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD:  need_scan = !failed_reg && !alpha_zero;
            CMD_DIFF: need_scan = differs && (emitted_reg < dirty_cap_reg);
            default:  need_scan = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_DECIDE;
            ST_DECIDE: state_next = need_scan ? ST_SCAN : ST_FINISH;
            ST_SCAN:   if (scan_rsp.done) state_next = ST_FINISH;
            ST_FINISH: if (!has_res_reg || slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready       = 1'b0;
        scan_req.start = 1'b0;
        scan_req.key   = pixel_reg[31:8];
        scan_hit_done  = 1'b0;
        fin_fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_DECIDE: scan_req.start = need_scan;
            ST_SCAN:   scan_hit_done = scan_rsp.done;
            ST_FINISH: fin_fire = !has_res_reg || slot_free;
            default:   in_ready = 1'b0;
        endcase
    end

    assign pal_wr_en    = scan_hit_done && (cmd_reg == CMD_ADD) && !scan_rsp.found && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RST;
            dirty_cap_reg   <= DIRTY_CAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_data[8:0];
                CFG_DIRTY_CAP:   dirty_cap_reg   <= cfg_data;
                default:         dirty_cap_reg   <= dirty_cap_reg;
            endcase
        end
    end

    // palette count, fail flag and record count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            failed_reg  <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            if (accept && start_req)
            begin
                emitted_reg <= '0;
                if (command == CMD_ADD)
                begin
                    count_reg  <= '0;
                    failed_reg <= 1'b0;
                end
            end
            if (pal_wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (scan_hit_done && (cmd_reg == CMD_ADD) && !scan_rsp.found && !room)
            begin
                failed_reg <= 1'b1;
            end
            if (fin_fire && has_res_reg && (cmd_reg == CMD_DIFF))
            begin
                emitted_reg <= emitted_reg + 17'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            pixel_reg    <= pixel;
            prev_reg     <= prev_pixel;
            has_prev_reg <= has_prev;
        end
    end

    // result being formed for the current word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_res_reg <= 1'b0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            has_res_reg <= (cmd_reg == CMD_ADD) || need_scan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            res_idx_reg <= 8'd0;
            priority if (cmd_reg == CMD_DIFF)
            begin
                res_status_reg <= STATUS_OK;
            end
            else if (failed_reg)
            begin
                res_status_reg <= STATUS_FAIL;
            end
            else if (alpha_zero)
            begin
                res_status_reg <= STATUS_SKIP;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
            end
        end
        else if (scan_hit_done)
        begin
            priority if (scan_rsp.found)
            begin
                res_idx_reg <= scan_rsp.index;
            end
            else if (cmd_reg == CMD_DIFF)
            begin
                res_idx_reg <= 8'd0;
            end
            else if (room)
            begin
                res_idx_reg <= 8'(count_reg[IDX_W-1:0]);
            end
            else
            begin
                res_idx_reg    <= 8'd0;
                res_status_reg <= STATUS_FAIL;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire && has_res_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire && has_res_reg)
        begin
            out_kind_reg   <= (cmd_reg == CMD_DIFF) ? KIND_DIRTY : KIND_ACK;
            out_x_reg      <= column;
            out_y_reg      <= row;
            out_idx_reg    <= res_idx_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign palette_index = out_idx_reg;
    assign status        = out_status_reg;

    pfde_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (pixel_reg[31:8]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfde_scan #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .count   (count_reg),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rsp     (scan_rsp)
    );

    pfde_position #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept && start_req),
        .advance     (fin_fire),
        .frame_width (frame_width_reg),
        .column      (column),
        .row         (row)
    );

    `PFDE_ASSERT(a_accept_to_decide, clk, rst_n, accept |=> (state_reg == ST_DECIDE))
    `PFDE_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(PALETTE_DEPTH))
    `PFDE_ASSERT(a_write_on_miss, clk, rst_n, pal_wr_en |-> (scan_rsp.done && !scan_rsp.found))
    `PFDE_ASSERT(a_scan_to_finish, clk, rst_n, scan_hit_done |=> (state_reg == ST_FINISH))

endmodule

`default_nettype wire

[dv/palette_frame_delta_encoder_top_tb.sv]
// Self-checking testbench of palette_frame_delta_encoder_top: random palette and diff traffic.

import pfde_pkg::*;

localparam int TABLE_DEPTH = 256;
localparam int DIM_LIMIT   = 256;

typedef struct packed {
    logic        command;
    logic        start_req;
    logic [31:0] pixel;
    logic [31:0] prev_pixel;
    logic        has_prev;
} pixel_word_t;

typedef struct packed {
    logic       kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] palette_index;
    logic [1:0] status;
} delta_record_t;

// Tracks palette, raster position and dirty count; holds the records still owed by the block.
class palette_delta_scoreboard;
    logic [23:0]   shade_table [TABLE_DEPTH];
    int unsigned   shades_held;
    bit            palette_broken;
    int unsigned   column;
    int unsigned   row;
    int unsigned   records_sent;
    int unsigned   row_width;
    int unsigned   record_cap;
    delta_record_t awaited[$];
    int unsigned   mismatches;

    function new();
        row_width  = FRAME_WIDTH_RST;
        record_cap = DIRTY_CAP_RST;
    endfunction

    function void set_reg(logic idx, logic [16:0] value);
        if (idx == CFG_FRAME_WIDTH)
            row_width = value[8:0];
        else
            record_cap = value;
    endfunction

    function bit find_shade(logic [23:0] rgb, output logic [7:0] slot);
        slot = '0;
        for (int i = 0; i < shades_held; i++)
        begin
            if (shade_table[i] == rgb)
            begin
                slot = 8'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void take_pixel(pixel_word_t w);
        delta_record_t rec;
        logic [7:0]    slot;
        int unsigned   span;
        bit            differs;

        if (w.start_req)
        begin
            column       = 0;
            row          = 0;
            records_sent = 0;
            if (w.command == CMD_ADD)
            begin
                shades_held    = 0;
                palette_broken = 1'b0;
            end
        end
        rec.kind          = KIND_ACK;
        rec.pixel_x       = 8'(column);
        rec.pixel_y       = 8'(row);
        rec.palette_index = '0;
        rec.status        = STATUS_OK;

        if (w.command == CMD_ADD)
        begin
            if (palette_broken)
                rec.status = STATUS_FAIL;
            else if (w.pixel[7:0] == 8'd0)
                rec.status = STATUS_SKIP;
            else if (find_shade(w.pixel[31:8], slot))
                rec.palette_index = slot;
            else if (shades_held < TABLE_DEPTH)
            begin
                rec.palette_index         = 8'(shades_held);
                shade_table[shades_held]  = w.pixel[31:8];
                shades_held++;
            end
            else
            begin
                palette_broken = 1'b1;
                rec.status     = STATUS_FAIL;
            end
            awaited.push_back(rec);
        end
        else
        begin
            differs = w.has_prev ? (w.pixel != w.prev_pixel) : (w.pixel[7:0] != 8'd0);
            if (differs && records_sent < record_cap)
            begin
                rec.kind = KIND_DIRTY;
                if (find_shade(w.pixel[31:8], slot))
                    rec.palette_index = slot;
                records_sent++;
                awaited.push_back(rec);
            end
        end

        // advance the raster position; width 0 acts as 1, wide rows clip at the bound
        span = (row_width == 0) ? 1 : ((row_width > DIM_LIMIT) ? DIM_LIMIT : row_width);
        if (column + 1 >= span)
        begin
            column = 0;
            if (row + 1 < DIM_LIMIT)
                row++;
        end
        else
            column++;
    endfunction

    function string show_record(delta_record_t r);
        return $sformatf("kind %0d x %0d y %0d index %0d status %0d",
                         r.kind, r.pixel_x, r.pixel_y, r.palette_index, r.status);
    endfunction

    function void match_record(delta_record_t got);
        delta_record_t want;

        if (awaited.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: %s", show_record(got));
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.pixel_x !== want.pixel_x
            || got.pixel_y !== want.pixel_y || got.palette_index !== want.palette_index
            || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("record mismatch: expected %s, got %s",
                         show_record(want), show_record(got));
        end
    endfunction
endclass

module palette_frame_delta_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_TOTAL    = 1850;
    localparam int CALM_WORDS     = 200;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [23:0] SHADE_A   = 24'hA53C7E;
    localparam logic [23:0] SHADE_B   = 24'h123456;
    localparam logic [23:0] SHADE_NEW = 24'h5AC30F;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [16:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        command    = 1'b0;
    logic        start_req  = 1'b0;
    logic [31:0] pixel      = '0;
    logic [31:0] prev_pixel = '0;
    logic        has_prev   = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        kind;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  palette_index;
    logic [1:0]  status;

    palette_delta_scoreboard sb;
    delta_record_t seen_record;
    int unsigned words_sent   = 0;
    int unsigned idle_odds    = 3;
    bit          calm         = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;

    palette_frame_delta_encoder_top #(
        .PALETTE_DEPTH (TABLE_DEPTH),
        .MAX_DIM       (DIM_LIMIT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .start_req     (start_req),
        .pixel         (pixel),
        .prev_pixel    (prev_pixel),
        .has_prev      (has_prev),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .palette_index (palette_index),
        .status        (status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stall the result side in short bursts.
    always @(posedge clk)
    begin
        if (stall_left == 0 && !calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            seen_record.kind          = kind;
            seen_record.pixel_x       = pixel_x;
            seen_record.pixel_y       = pixel_y;
            seen_record.palette_index = palette_index;
            seen_record.status        = status;
            sb.match_record(seen_record);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("palette_frame_delta_encoder_top test failed");
            $finish;
        end
    end

    function automatic pixel_word_t make_word(logic cmd, logic first, logic [31:0] px,
                                              logic [31:0] prev, logic hp);
        pixel_word_t w;
        w.command    = cmd;
        w.start_req  = first;
        w.pixel      = px;
        w.prev_pixel = prev;
        w.has_prev   = hp;
        return w;
    endfunction

    task automatic send_word(input pixel_word_t w);
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= w.command;
        start_req  <= w.start_req;
        pixel      <= w.pixel;
        prev_pixel <= w.prev_pixel;
        has_prev   <= w.has_prev;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.take_pixel(w);
        words_sent++;
        if (words_sent >= ITEMS_TOTAL - CALM_WORDS)
            calm = 1'b1;
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 9) == 0)
            send_word(make_word(1'($urandom), $urandom_range(0, 7) == 0, $urandom, $urandom,
                                1'($urandom)));
    endtask

    // Drop valid, drain the owed records, then give a word with no result time to finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [8:0] width, input logic [16:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= {8'd0, width};
        @(posedge clk);
        sb.set_reg(CFG_FRAME_WIDTH, {8'd0, width});
        cfg_index <= CFG_DIRTY_CAP;
        cfg_data  <= cap;
        @(posedge clk);
        sb.set_reg(CFG_DIRTY_CAP, cap);
        cfg_we <= 1'b0;
    endtask

    // One build pass over a small colour set, then one or two diff passes.
    task automatic send_frame();
        logic [23:0] shades[$];
        logic [23:0] shade;
        logic [31:0] px;
        logic [31:0] prev;
        logic        hp;
        int unsigned n_px;

        repeat ($urandom_range(1, 12)) shades.push_back(24'($urandom));
        n_px = $urandom_range(6, 40);
        for (int i = 0; i < n_px; i++)
        begin
            shade = shades[$urandom_range(0, shades.size() - 1)];
            px = {shade, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255))};
            send_word(make_word(CMD_ADD, i == 0, px, $urandom, 1'($urandom)));
            send_noise();
        end
        repeat ($urandom_range(1, 2))
        begin
            hp = $urandom_range(0, 3) != 0;
            for (int i = 0; i < n_px; i++)
            begin
                shade = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                    : shades[$urandom_range(0, shades.size() - 1)];
                px = {shade, ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom)};
                case ($urandom_range(0, 3))
                    0, 1:    prev = px;
                    2:       prev = px ^ (32'd1 << $urandom_range(0, 31));
                    default: prev = $urandom;
                endcase
                if ($urandom_range(0, 19) == 0)
                    hp = ~hp;
                send_word(make_word(CMD_DIFF, i == 0, px, prev, hp));
                send_noise();
            end
        end
    endtask

    initial
    begin
        logic [23:0] fill_shades[$];
        bit          seen [logic [23:0]];
        logic [23:0] shade;
        logic [31:0] px;
        logic [8:0]  width;
        logic [16:0] cap;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: duplicates, transparency, dirty rules, absent colours.
        send_word(make_word(CMD_ADD, 1'b1, {SHADE_A, 8'hFF}, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 1'b0, {SHADE_A, 8'h01}, 32'hFFFFFFFF, 1'b1));
        send_word(make_word(CMD_ADD, 1'b0, {SHADE_B, 8'h00}, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 1'b0, {SHADE_B, 8'h80}, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
        send_word(make_word(CMD_ADD, 1'b0, 32'h000000FF, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 1'b0, 32'h00000000, 32'h0, 1'b0));
        send_word(make_word(CMD_DIFF, 1'b1, {SHADE_A, 8'hFF}, 32'h0, 1'b0));
        send_word(make_word(CMD_DIFF, 1'b0, {SHADE_B, 8'h00}, 32'hFFFFFFFF, 1'b0));
        send_word(make_word(CMD_DIFF, 1'b0, {SHADE_B, 8'h80}, {SHADE_B, 8'h80}, 1'b1));
        send_word(make_word(CMD_DIFF, 1'b0, {SHADE_B, 8'h81}, {SHADE_B, 8'h80}, 1'b1));
        send_word(make_word(CMD_DIFF, 1'b0, {SHADE_NEW, 8'hFF}, 32'h0, 1'b1));
        send_word(make_word(CMD_DIFF, 1'b0, 32'hFFFFFFFF, 32'h0, 1'b1));
        send_word(make_word(CMD_DIFF, 1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1));
        send_word(make_word(CMD_DIFF, 1'b1, {SHADE_B, 8'h80}, {SHADE_A, 8'h80}, 1'b1));
        send_word(make_word(CMD_ADD, 1'b0, {SHADE_NEW, 8'h7F}, 32'h0, 1'b0));
        send_word(make_word(CMD_DIFF, 1'b0, 32'h00000000, 32'h12345678, 1'b0));
        settle();

        // Overfill the palette at the widest row, then look up random filled entries.
        write_regs(9'd256, 17'd65536);
        idle_odds = 2;
        while (fill_shades.size() < TABLE_DEPTH + 2)
        begin
            shade = 24'($urandom);
            if (!seen.exists(shade))
            begin
                seen[shade] = 1'b1;
                fill_shades.push_back(shade);
            end
        end
        foreach (fill_shades[i])
            send_word(make_word(CMD_ADD, i == 0, {fill_shades[i], 8'($urandom_range(1, 255))},
                                $urandom, 1'($urandom)));
        send_word(make_word(CMD_ADD, 1'b0, {fill_shades[1], 8'h00}, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 1'b0, {fill_shades[0], 8'hFF}, 32'h0, 1'b0));
        for (int i = 0; i < 30; i++)
        begin
            shade = fill_shades[$urandom_range(0, fill_shades.size() - 1)];
            send_word(make_word(CMD_DIFF, i == 0, {shade, 8'($urandom)}, $urandom, 1'b1));
        end
        settle();

        // One pixel per row: run the row counter into saturation.
        write_regs(9'd1, 17'd65536);
        idle_odds = 0;
        for (int i = 0; i < 270; i++)
        begin
            px = {fill_shades[$urandom_range(0, fill_shades.size() - 1)], 8'($urandom)};
            send_word(make_word(CMD_DIFF, i == 0, px,
                                ($urandom_range(0, 3) == 0) ? ~px : px, 1'b1));
        end
        send_word(make_word(CMD_ADD, 1'b0, {SHADE_NEW, 8'h11}, 32'h0, 1'b0));

        for (int phase = 0; words_sent < ITEMS_TOTAL; phase++)
        begin
            case (phase)
                0:
                begin
                    width = 9'd0;
                    cap   = 17'd0;
                end
                1:
                begin
                    width = 9'd511;
                    cap   = 17'h1FFFF;
                end
                2:
                begin
                    width = 9'd256;
                    cap   = 17'd3;
                end
                3:
                begin
                    width = FRAME_WIDTH_RST;
                    cap   = DIRTY_CAP_RST;
                end
                default:
                begin
                    width = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                        : 9'($urandom_range(1, 24));
                    cap   = ($urandom_range(0, 3) == 0) ? 17'd65536
                                                        : 17'($urandom_range(0, 30));
                end
            endcase
            settle();
            write_regs(width, cap);
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 2;
                default: idle_odds = 5;
            endcase
            repeat ($urandom_range(1, 3)) send_frame();
        end

        settle();
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("palette_frame_delta_encoder_top test passed");
        else
            $display("palette_frame_delta_encoder_top test failed");
        $finish;
    end
endmodule
